FILE: src/qcoc_pkg.sv
// ----------------------------------------------------------------------------
// Quad corner order check package
// Shared types and constants for the corner ordering and shape check.
// ----------------------------------------------------------------------------
package qcoc_pkg;

  localparam int AREA_W = 35;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  typedef logic [1:0] idx_t;

  typedef struct packed {
    idx_t lox;
    idx_t loy;
    idx_t hix;
    idx_t hiy;
    logic ord;
  } order_t;

endpackage

FILE: src/quad_corner_order_check_unit.sv
// ----------------------------------------------------------------------------
// Quad corner order check unit
// Pipeline: an accepted word is held in the input registers and its result,
// with out_valid high, in the result registers that drive the result ports.
// Throughput: one word per cycle; busy stays low since the receiver cannot
// stall and the two-register pipeline (input, result) never backs up.
// Reset: synchronous active-low reset clears the pipeline valid flags only.
// ----------------------------------------------------------------------------
// Reorders the four corners of a marker quadrilateral by the extremes of the
// edge sums and reports order validity, convexity and a parallelogram area.
// ----------------------------------------------------------------------------
module quad_corner_order_check_unit
  import qcoc_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_corner_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_d_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_d_y,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_corner_a_x,
  output logic signed [COORD_WIDTH-1:0] out_corner_a_y,
  output logic signed [COORD_WIDTH-1:0] out_corner_b_x,
  output logic signed [COORD_WIDTH-1:0] out_corner_b_y,
  output logic signed [COORD_WIDTH-1:0] out_corner_c_x,
  output logic signed [COORD_WIDTH-1:0] out_corner_c_y,
  output logic signed [COORD_WIDTH-1:0] out_corner_d_x,
  output logic signed [COORD_WIDTH-1:0] out_corner_d_y,
  output logic [1:0]                    out_first_index,
  output logic                          out_order_valid,
  output logic                          out_convex_flag,
  output logic [AREA_W-1:0]             out_area_value
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * DW;
  localparam int CW    = PW + 1;
  localparam int EXT_W = (CW > AREA_W) ? CW : AREA_W;

  logic                          accept;
  logic                          v1_r, out_valid_r;
  logic signed [COORD_WIDTH-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r, dx_r, dy_r;

  logic signed [COORD_WIDTH-1:0] px [4];
  logic signed [COORD_WIDTH-1:0] py [4];
  logic signed [DW-1:0]          sx [4];
  logic signed [DW-1:0]          sy [4];
  logic signed [DW-1:0]          ex [4];
  logic signed [DW-1:0]          ey [4];
  logic signed [PW-1:0]          pa [4];
  logic signed [PW-1:0]          pb [4];
  logic signed [DW-1:0]          ux, uy, vx, vy;
  logic signed [PW-1:0]          qa, qb;
  order_t                        order_nxt;
  logic signed [COORD_WIDTH-1:0] selx [4];
  logic signed [COORD_WIDTH-1:0] sely [4];

  logic                          convex_nxt;
  logic signed [CW-1:0]          ar;
  logic [CW-1:0]                 ar_mag;
  logic [EXT_W-1:0]              ar_ext;
  logic [AREA_W-1:0]             area_nxt;

  logic signed [COORD_WIDTH-1:0] ocx_r [4];
  logic signed [COORD_WIDTH-1:0] ocy_r [4];
  idx_t                          first_r;
  logic                          ord_out_r, convex_r;
  logic [AREA_W-1:0]             area_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax_r <= in_corner_a_x;
      ay_r <= in_corner_a_y;
      bx_r <= in_corner_b_x;
      by_r <= in_corner_b_y;
      cx_r <= in_corner_c_x;
      cy_r <= in_corner_c_y;
      dx_r <= in_corner_d_x;
      dy_r <= in_corner_d_y;
    end
  end

  assign px[0] = ax_r;
  assign px[1] = bx_r;
  assign px[2] = cx_r;
  assign px[3] = dx_r;
  assign py[0] = ay_r;
  assign py[1] = by_r;
  assign py[2] = cy_r;
  assign py[3] = dy_r;

  for (genvar g = 0; g < 4; g++) begin : g_edge
    localparam int N = (g + 1) % 4;
    assign sx[g] = DW'(px[g]) + DW'(px[N]);
    assign sy[g] = DW'(py[g]) + DW'(py[N]);
    assign ex[g] = DW'(px[N]) - DW'(px[g]);
    assign ey[g] = DW'(py[N]) - DW'(py[g]);
  end

  for (genvar g = 0; g < 4; g++) begin : g_turn
    localparam int N = (g + 1) % 4;
    assign pa[g] = ex[g] * ey[N];
    assign pb[g] = ey[g] * ex[N];
  end

  assign ux = DW'(ax_r) - DW'(bx_r);
  assign uy = DW'(ay_r) - DW'(by_r);
  assign vx = DW'(cx_r) - DW'(bx_r);
  assign vy = DW'(cy_r) - DW'(by_r);
  assign qa = ux * vy;
  assign qb = uy * vx;

  always_comb begin
    logic signed [DW-1:0] blx, bhx, bly, bhy;
    blx = sx[0];
    bhx = sx[0];
    bly = sy[0];
    bhy = sy[0];
    order_nxt = '0;
    for (int i = 1; i < 4; i++) begin
      if (sx[i] < blx) begin
        blx = sx[i];
        order_nxt.lox = idx_t'(i);
      end
      if (sx[i] > bhx) begin
        bhx = sx[i];
        order_nxt.hix = idx_t'(i);
      end
      if (sy[i] < bly) begin
        bly = sy[i];
        order_nxt.loy = idx_t'(i);
      end
      if (sy[i] > bhy) begin
        bhy = sy[i];
        order_nxt.hiy = idx_t'(i);
      end
    end
    order_nxt.ord = (order_nxt.lox != order_nxt.loy) && (order_nxt.lox != order_nxt.hix) &&
                    (order_nxt.lox != order_nxt.hiy) && (order_nxt.loy != order_nxt.hix) &&
                    (order_nxt.loy != order_nxt.hiy) && (order_nxt.hix != order_nxt.hiy);
  end

  always_comb begin
    idx_t sel [4];
    sel[0] = order_nxt.lox;
    sel[1] = order_nxt.loy;
    sel[2] = order_nxt.hix;
    sel[3] = order_nxt.hiy;
    for (int k = 0; k < 4; k++) begin
      case (sel[k])
        2'd0: begin
          selx[k] = px[0];
          sely[k] = py[0];
        end
        2'd1: begin
          selx[k] = px[1];
          sely[k] = py[1];
        end
        2'd2: begin
          selx[k] = px[2];
          sely[k] = py[2];
        end
        default: begin
          selx[k] = px[3];
          sely[k] = py[3];
        end
      endcase
    end
  end

  always_comb begin
    logic signed [CW-1:0] t;
    convex_nxt = 1'b1;
    for (int i = 0; i < 4; i++) begin
      t = CW'(pa[i]) - CW'(pb[i]);
      if (t[CW-1]) begin
        convex_nxt = 1'b0;
      end
    end
  end

  assign ar       = CW'(qa) - CW'(qb);
  assign ar_mag   = ar[CW-1] ? CW'(-ar) : CW'(ar);
  assign ar_ext   = EXT_W'(ar_mag);
  assign area_nxt = (ar_ext > EXT_W'(AREA_MAX)) ? AREA_MAX : ar_ext[AREA_W-1:0];

  always_ff @(posedge clk) begin
    if (v1_r) begin
      for (int i = 0; i < 4; i++) begin
        ocx_r[i] <= selx[i];
        ocy_r[i] <= sely[i];
      end
      first_r   <= order_nxt.lox;
      ord_out_r <= order_nxt.ord;
      convex_r  <= convex_nxt;
      area_r    <= area_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_corner_a_x  = ocx_r[0];
  assign out_corner_a_y  = ocy_r[0];
  assign out_corner_b_x  = ocx_r[1];
  assign out_corner_b_y  = ocy_r[1];
  assign out_corner_c_x  = ocx_r[2];
  assign out_corner_c_y  = ocy_r[2];
  assign out_corner_d_x  = ocx_r[3];
  assign out_corner_d_y  = ocy_r[3];
  assign out_first_index = first_r;
  assign out_order_valid = ord_out_r;
  assign out_convex_flag = convex_r;
  assign out_area_value  = area_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("Result word without a matching accepted word.");

  a_order_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && order_nxt.ord) |->
      (((4'b0001 << order_nxt.lox) | (4'b0001 << order_nxt.loy) |
        (4'b0001 << order_nxt.hix) | (4'b0001 << order_nxt.hiy)) == 4'b1111))
    else $error("Valid order does not cover all four corners.");

  a_first_follows: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |=> (out_valid && out_first_index == $past(order_nxt.lox)))
    else $error("First index lost between stages.");
`endif

endmodule

FILE: tb/sv/quad_order_scoreboard.sv
// ----------------------------------------------------------------------------
// Quad corner order scoreboard
// Watches the command and result channels of the corner order check unit.
// Each accepted word is turned into its expected result by an independent
// predictor. Each result word is then compared, field by field, with the
// oldest expectation.
// ----------------------------------------------------------------------------
module quad_order_scoreboard
  import qcoc_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic signed [CW-1:0] in_corner_a_x,
  input  logic signed [CW-1:0] in_corner_a_y,
  input  logic signed [CW-1:0] in_corner_b_x,
  input  logic signed [CW-1:0] in_corner_b_y,
  input  logic signed [CW-1:0] in_corner_c_x,
  input  logic signed [CW-1:0] in_corner_c_y,
  input  logic signed [CW-1:0] in_corner_d_x,
  input  logic signed [CW-1:0] in_corner_d_y,
  input  logic                 out_valid,
  input  logic signed [CW-1:0] out_corner_a_x,
  input  logic signed [CW-1:0] out_corner_a_y,
  input  logic signed [CW-1:0] out_corner_b_x,
  input  logic signed [CW-1:0] out_corner_b_y,
  input  logic signed [CW-1:0] out_corner_c_x,
  input  logic signed [CW-1:0] out_corner_c_y,
  input  logic signed [CW-1:0] out_corner_d_x,
  input  logic signed [CW-1:0] out_corner_d_y,
  input  logic [1:0]           out_first_index,
  input  logic                 out_order_valid,
  input  logic                 out_convex_flag,
  input  logic [AREA_W-1:0]    out_area_value,
  output int                   mismatches,
  output int                   pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0][CW-1:0] ox;
    logic [3:0][CW-1:0] oy;
    idx_t               first;
    logic               ord;
    logic               convex;
    logic [AREA_W-1:0]  area;
  } corner_order_t;

  corner_order_t expected_orders[$];
  int            err_tally = 0;

  initial begin
    mismatches    = 0;
    pending_words = 0;
  end

  function automatic corner_order_t predict_corner_order(input logic [3:0][CW-1:0] qx,
                                                         input logic [3:0][CW-1:0] qy);
    corner_order_t r;
    longint        px[4];
    longint        py[4];
    longint        sx[4];
    longint        sy[4];
    longint        turn;
    int            lox;
    int            loy;
    int            hix;
    int            hiy;
    int            sel[4];
    int            n;
    int            nn;
    for (int i = 0; i < 4; i++) begin
      px[i] = $signed(qx[i]);
      py[i] = $signed(qy[i]);
    end
    for (int i = 0; i < 4; i++) begin
      sx[i] = px[i] + px[(i + 1) % 4];
      sy[i] = py[i] + py[(i + 1) % 4];
    end
    lox = 0;
    loy = 0;
    hix = 0;
    hiy = 0;
    for (int i = 1; i < 4; i++) begin
      if (sx[i] < sx[lox]) lox = i;
      if (sx[i] > sx[hix]) hix = i;
      if (sy[i] < sy[loy]) loy = i;
      if (sy[i] > sy[hiy]) hiy = i;
    end
    sel[0] = lox;
    sel[1] = loy;
    sel[2] = hix;
    sel[3] = hiy;
    r.ord = (lox != loy) && (lox != hix) && (lox != hiy) &&
            (loy != hix) && (loy != hiy) && (hix != hiy);
    r.convex = 1'b1;
    for (int i = 0; i < 4; i++) begin
      n = (i + 1) % 4;
      nn = (i + 2) % 4;
      turn = (px[n] - px[i]) * (py[nn] - py[n]) - (py[n] - py[i]) * (px[nn] - px[n]);
      if (turn < 0) r.convex = 1'b0;
    end
    turn = (px[0] - px[1]) * (py[2] - py[1]) - (py[0] - py[1]) * (px[2] - px[1]);
    if (turn < 0) turn = -turn;
    if (turn > longint'(AREA_MAX)) turn = longint'(AREA_MAX);
    r.area = turn[AREA_W-1:0];
    for (int i = 0; i < 4; i++) begin
      r.ox[i] = qx[sel[i]];
      r.oy[i] = qy[sel[i]];
    end
    r.first = lox[1:0];
    return r;
  endfunction

  function automatic int check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    corner_order_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_orders.size() == 0) begin
          $error("result word with no expectation waiting");
          err_tally++;
        end else begin
          want = expected_orders.pop_front();
          err_tally += check_field("out_corner_a_x", $signed(want.ox[0]), out_corner_a_x);
          err_tally += check_field("out_corner_a_y", $signed(want.oy[0]), out_corner_a_y);
          err_tally += check_field("out_corner_b_x", $signed(want.ox[1]), out_corner_b_x);
          err_tally += check_field("out_corner_b_y", $signed(want.oy[1]), out_corner_b_y);
          err_tally += check_field("out_corner_c_x", $signed(want.ox[2]), out_corner_c_x);
          err_tally += check_field("out_corner_c_y", $signed(want.oy[2]), out_corner_c_y);
          err_tally += check_field("out_corner_d_x", $signed(want.ox[3]), out_corner_d_x);
          err_tally += check_field("out_corner_d_y", $signed(want.oy[3]), out_corner_d_y);
          err_tally += check_field("out_first_index", want.first, out_first_index);
          err_tally += check_field("out_order_valid", want.ord, out_order_valid);
          err_tally += check_field("out_convex_flag", want.convex, out_convex_flag);
          err_tally += check_field("out_area_value", want.area, out_area_value);
        end
      end
      if (start && !busy) begin
        expected_orders.insert(expected_orders.size(), predict_corner_order(
          {in_corner_d_x, in_corner_c_x, in_corner_b_x, in_corner_a_x},
          {in_corner_d_y, in_corner_c_y, in_corner_b_y, in_corner_a_y}));
      end
    end
    mismatches    <= err_tally;
    pending_words <= expected_orders.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Quad corner order check testbench
// Drives directed and random corner sets into the unit with varying input
// gaps, while a scoreboard beside the unit predicts and checks every result.
// ----------------------------------------------------------------------------
module testbench;
  import qcoc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW             = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 200;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CW-1:0] in_corner_a_x = '0;
  logic signed [CW-1:0] in_corner_a_y = '0;
  logic signed [CW-1:0] in_corner_b_x = '0;
  logic signed [CW-1:0] in_corner_b_y = '0;
  logic signed [CW-1:0] in_corner_c_x = '0;
  logic signed [CW-1:0] in_corner_c_y = '0;
  logic signed [CW-1:0] in_corner_d_x = '0;
  logic signed [CW-1:0] in_corner_d_y = '0;
  logic                 out_valid;
  logic signed [CW-1:0] out_corner_a_x;
  logic signed [CW-1:0] out_corner_a_y;
  logic signed [CW-1:0] out_corner_b_x;
  logic signed [CW-1:0] out_corner_b_y;
  logic signed [CW-1:0] out_corner_c_x;
  logic signed [CW-1:0] out_corner_c_y;
  logic signed [CW-1:0] out_corner_d_x;
  logic signed [CW-1:0] out_corner_d_y;
  logic [1:0]           out_first_index;
  logic                 out_order_valid;
  logic                 out_convex_flag;
  logic [AREA_W-1:0]    out_area_value;
  int                   mismatches;
  int                   pending_words;
  int                   quiet_cycles = 0;
  int                   sender_idle_pct = 0;
  int                   qx[4];
  int                   qy[4];

  quad_corner_order_check_unit #(
    .COORD_WIDTH(CW)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_corner_a_x(in_corner_a_x),
    .in_corner_a_y(in_corner_a_y),
    .in_corner_b_x(in_corner_b_x),
    .in_corner_b_y(in_corner_b_y),
    .in_corner_c_x(in_corner_c_x),
    .in_corner_c_y(in_corner_c_y),
    .in_corner_d_x(in_corner_d_x),
    .in_corner_d_y(in_corner_d_y),
    .out_valid(out_valid),
    .out_corner_a_x(out_corner_a_x),
    .out_corner_a_y(out_corner_a_y),
    .out_corner_b_x(out_corner_b_x),
    .out_corner_b_y(out_corner_b_y),
    .out_corner_c_x(out_corner_c_x),
    .out_corner_c_y(out_corner_c_y),
    .out_corner_d_x(out_corner_d_x),
    .out_corner_d_y(out_corner_d_y),
    .out_first_index(out_first_index),
    .out_order_valid(out_order_valid),
    .out_convex_flag(out_convex_flag),
    .out_area_value(out_area_value)
  );

  quad_order_scoreboard #(
    .CW(CW)
  ) u_scoreboard (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_corner_a_x(in_corner_a_x),
    .in_corner_a_y(in_corner_a_y),
    .in_corner_b_x(in_corner_b_x),
    .in_corner_b_y(in_corner_b_y),
    .in_corner_c_x(in_corner_c_x),
    .in_corner_c_y(in_corner_c_y),
    .in_corner_d_x(in_corner_d_x),
    .in_corner_d_y(in_corner_d_y),
    .out_valid(out_valid),
    .out_corner_a_x(out_corner_a_x),
    .out_corner_a_y(out_corner_a_y),
    .out_corner_b_x(out_corner_b_x),
    .out_corner_b_y(out_corner_b_y),
    .out_corner_c_x(out_corner_c_x),
    .out_corner_c_y(out_corner_c_y),
    .out_corner_d_x(out_corner_d_x),
    .out_corner_d_y(out_corner_d_y),
    .out_first_index(out_first_index),
    .out_order_valid(out_order_valid),
    .out_convex_flag(out_convex_flag),
    .out_area_value(out_area_value),
    .mismatches(mismatches),
    .pending_words(pending_words)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_quad();
    in_corner_a_x <= qx[0][CW-1:0];
    in_corner_a_y <= qy[0][CW-1:0];
    in_corner_b_x <= qx[1][CW-1:0];
    in_corner_b_y <= qy[1][CW-1:0];
    in_corner_c_x <= qx[2][CW-1:0];
    in_corner_c_y <= qy[2][CW-1:0];
    in_corner_d_x <= qx[3][CW-1:0];
    in_corner_d_y <= qy[3][CW-1:0];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic directed_quad(input int ax, input int ay, input int bx, input int by,
                               input int cx, input int cy, input int dx, input int dy);
    qx = '{ax, bx, cx, dx};
    qy = '{ay, by, cy, dy};
    send_quad();
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic make_random_quad();
    int kind;
    int mx;
    int my;
    int w;
    int h;
    int rot;
    int rev;
    int k;
    int bx[4];
    int by[4];
    kind = $urandom_range(99);
    if (kind < 50) begin
      // Well-formed marker: a diamond around a center, rotated start, either winding.
      mx = int'($urandom_range(32000)) - 16000;
      my = int'($urandom_range(32000)) - 16000;
      w = $urandom_range(8000, 1);
      h = $urandom_range(8000, 1);
      bx = '{mx - w, mx + int'($urandom_range(w / 2)) - w / 4, mx + w,
             mx + int'($urandom_range(w / 2)) - w / 4};
      by = '{my + int'($urandom_range(h / 2)) - h / 4, my - h,
             my + int'($urandom_range(h / 2)) - h / 4, my + h};
      rot = $urandom_range(3);
      rev = $urandom_range(1);
      for (int i = 0; i < 4; i++) begin
        k = rev ? ((rot - i + 8) % 4) : ((rot + i) % 4);
        qx[i] = bx[k];
        qy[i] = by[k];
      end
    end else if (kind < 70) begin
      for (int i = 0; i < 4; i++) begin
        qx[i] = $urandom;
        qy[i] = $urandom;
      end
    end else if (kind < 85) begin
      for (int i = 0; i < 4; i++) begin
        qx[i] = int'($urandom_range(6)) - 3;
        qy[i] = int'($urandom_range(6)) - 3;
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        qx[i] = int'($urandom_range(2000)) - 1000;
        qy[i] = int'($urandom_range(2000)) - 1000;
      end
      k = $urandom_range(3);
      qx[(k + 1) % 4] = qx[k];
      qy[(k + 1 + int'($urandom_range(2))) % 4] = qy[k];
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_quad(0, 0, 0, 0, 0, 0, 0, 0);
    directed_quad(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    directed_quad(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    directed_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767);
    directed_quad(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768);
    directed_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, -32768);
    directed_quad(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767);
    directed_quad(-100, 0, 0, -100, 100, 0, 0, 100);
    directed_quad(0, 100, 100, 0, 0, -100, -100, 0);
    directed_quad(-160, -160, 160, -160, 160, 160, -160, 160);
    directed_quad(-160, -160, -160, 160, 160, 160, 160, -160);
    directed_quad(-160, -160, 160, 160, 160, -160, -160, 160);
    directed_quad(-160, -160, 0, 0, 160, 160, 320, 320);
    directed_quad(-160, -160, 160, -160, 0, -80, -160, 160);
    directed_quad(5, 5, 5, 5, 5, 5, -5, -5);
    directed_quad(16, 32, 16, 32, 48, 64, 48, 64);
    directed_quad(-21846, 21845, 21845, -21846, -21846, 21845, 21845, -21846);
    directed_quad(-1, 1, 1, -1, -1, 1, 1, -1);
    directed_quad(1000, -3000, -2000, 4000, 7000, 2000, -500, -6000);
    directed_quad(32767, 0, 0, 32767, -32768, 0, 0, -32768);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 9 : ((phase == 1) ? 48 : 0);
      repeat (PHASE_WORDS) begin
        make_random_quad();
        send_quad();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_words == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/qcoc_pkg.sv
src/quad_corner_order_check_unit.sv
tb/sv/quad_order_scoreboard.sv
tb/sv/testbench.sv
